// ----- hw/rtl/motor_speed_pi_controller_top_defines.svh -----
// Assertion macros shared by the controller RTL.
`ifndef MOTOR_SPEED_PI_CONTROLLER_TOP_DEFINES_SVH
`define MOTOR_SPEED_PI_CONTROLLER_TOP_DEFINES_SVH

// A property checked at every rising clock edge outside reset.
`define MSPI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define MSPI_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (trig) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/mspi_pkg.sv -----
package mspi_pkg;

    localparam int SPEED_BITS     = 24;
    localparam int GAIN_FRAC_BITS = 16;

    // Field and register widths.
    localparam int SET_W      = 16;
    localparam int PERIOD_W   = 32;
    localparam int DRIVE_W    = 16;
    localparam int MEAS_W     = 24;
    localparam int KP_W       = 24;
    localparam int KI_W       = 28;
    localparam int NUM_W      = 33;
    localparam int LIMIT_W    = 16;
    localparam int CFG_DATA_W = 33;
    localparam int CFG_IDX_W  = 3;

    // Integrator format Q16.24.
    localparam int ACC_FRAC = 24;
    localparam int ACC_W    = LIMIT_W + ACC_FRAC;

    // The proportional product is bounded at +/- 2^17 in integer units.
    localparam int P_BOUND_LOG2 = 17;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI_STEP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_NUMER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 3'd4;

    // Reset values.
    localparam logic [KP_W-1:0]     KP_RESET     = 24'd65536;
    localparam logic [KI_W-1:0]     KI_RESET     = 28'd41943;
    localparam logic [NUM_W-1:0]    NUM_RESET    = 33'd5040322581;
    localparam logic [PERIOD_W-1:0] MINP_RESET   = 32'd1000;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 16'd9500;

    typedef struct packed {
        logic [KP_W-1:0]     kp_gain;
        logic [KI_W-1:0]     ki_step;
        logic [NUM_W-1:0]    speed_numerator;
        logic [PERIOD_W-1:0] min_period;
        logic [LIMIT_W-1:0]  output_limit;
    } mspi_cfg_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic speed;
        logic err;
        logic mul;
        logic mul_sel_kp;
        logic integ;
        logic drive;
        logic out_load;
    } mspi_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SPEED,
        ST_ERR,
        ST_MUL_I,
        ST_INTEG,
        ST_DRIVE,
        ST_OUT
    } mspi_state_t;

endpackage

// ----- hw/rtl/mspi_cfg.sv -----
module mspi_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [mspi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mspi_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output mspi_pkg::mspi_cfg_t               cfg
);
    import mspi_pkg::*;

    mspi_cfg_t cfg_reg;
    mspi_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_KP_GAIN:      cfg_next.kp_gain         = cfg_wdata[KP_W-1:0];
                REG_KI_STEP:      cfg_next.ki_step         = cfg_wdata[KI_W-1:0];
                REG_SPEED_NUMER:  cfg_next.speed_numerator = cfg_wdata[NUM_W-1:0];
                REG_MIN_PERIOD:   cfg_next.min_period      = cfg_wdata[PERIOD_W-1:0];
                REG_OUTPUT_LIMIT: cfg_next.output_limit    = cfg_wdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp_gain         <= KP_RESET;
            cfg_reg.ki_step         <= KI_RESET;
            cfg_reg.speed_numerator <= NUM_RESET;
            cfg_reg.min_period      <= MINP_RESET;
            cfg_reg.output_limit    <= LIMIT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/mspi_dp.sv -----
module mspi_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [mspi_pkg::SET_W-1:0]      speed_set,
    input  logic [mspi_pkg::PERIOD_W-1:0]   period_ticks,
    input  mspi_pkg::mspi_cfg_t             cfg,
    input  mspi_pkg::mspi_cmd_t             cmd,
    output logic                            div_last,
    output logic [mspi_pkg::DRIVE_W-1:0]    drive_level,
    output logic [mspi_pkg::MEAS_W-1:0]     measured_speed
);
    import mspi_pkg::*;

    localparam int CNT_W   = $clog2(NUM_W);
    localparam int ERR_W   = SPEED_BITS + 1;
    localparam int MB_W    = KI_W + 1;
    localparam int PROD_W  = ERR_W + MB_W;
    localparam int ISUM_W  = PROD_W + 1;
    localparam int PC_W    = P_BOUND_LOG2 + GAIN_FRAC_BITS + 2;
    localparam int SHIFT   = ACC_FRAC - GAIN_FRAC_BITS;
    localparam int SUM_W   = P_BOUND_LOG2 + ACC_FRAC + 3;
    localparam int DI_W    = SUM_W - 1 - ACC_FRAC;

    localparam logic [CNT_W-1:0]         CNT_LAST  = CNT_W'(NUM_W - 1);
    localparam logic [SPEED_BITS-1:0]    SPEED_MAX = '1;
    localparam logic signed [PROD_W-1:0] PB_POS    =
        PROD_W'(1) <<< (P_BOUND_LOG2 + GAIN_FRAC_BITS);
    localparam logic signed [PROD_W-1:0] PB_NEG    = -PB_POS;

    // Operand latches.
    logic [SET_W-1:0]      set_reg;
    logic                  stopped_reg;
    logic [PERIOD_W-1:0]   div_reg;

    // Restoring divider: the numerator register shifts out dividend bits and
    // shifts in quotient bits, so it holds the quotient after NUM_W steps.
    logic [NUM_W-1:0]      num_reg;
    logic [PERIOD_W-1:0]   rem_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [PERIOD_W+1:0]   trial;

    logic [SPEED_BITS-1:0]     speed_reg;
    logic [SPEED_BITS-1:0]     speed_next;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [ACC_W-1:0]          acc_reg;
    logic [ACC_W-1:0]          acc_next;
    logic [ACC_W-1:0]          lim_acc;
    logic signed [ISUM_W-1:0]  isum;
    logic signed [PROD_W-1:0]  p_cl;
    logic signed [SUM_W-1:0]   pc_x;
    logic signed [SUM_W-1:0]   dsum;
    logic [DI_W-1:0]           d_int;
    logic [DRIVE_W-1:0]        drive_reg;
    logic [DRIVE_W-1:0]        drive_next;
    logic [DRIVE_W-1:0]        out_drive_reg;
    logic [MEAS_W-1:0]         out_speed_reg;

    assign trial = {1'b0, rem_reg, num_reg[NUM_W-1]} - {2'b00, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.load) begin
            cnt_reg <= '0;
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    assign div_last = cnt_reg == CNT_LAST;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            set_reg     <= speed_set;
            stopped_reg <= period_ticks <= cfg.min_period;
            div_reg     <= period_ticks;
            num_reg     <= cfg.speed_numerator;
            rem_reg     <= '0;
        end else if (cmd.div_step) begin
            if (!trial[PERIOD_W+1]) begin
                rem_reg <= trial[PERIOD_W-1:0];
                num_reg <= {num_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[PERIOD_W-2:0], num_reg[NUM_W-1]};
                num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    // Speed saturation; a stopped motor reads as zero speed.
    always_comb begin
        if (stopped_reg) begin
            speed_next = '0;
        end else if (|num_reg[NUM_W-1:SPEED_BITS]) begin
            speed_next = SPEED_MAX;
        end else begin
            speed_next = num_reg[SPEED_BITS-1:0];
        end
    end

    // One shared multiplier: integral gain first, then proportional gain.
    assign mul_b     = cmd.mul_sel_kp ? $signed(MB_W'(cfg.kp_gain))
                                      : $signed(MB_W'(cfg.ki_step));
    assign prod_next = err_reg * mul_b;

    // Integrator update with clamp to 0 .. output_limit.
    assign lim_acc = {cfg.output_limit, ACC_FRAC'(0)};
    assign isum    = $signed({{(ISUM_W-ACC_W){1'b0}}, acc_reg})
                   + $signed({prod_reg[PROD_W-1], prod_reg});

    always_comb begin
        if (isum[ISUM_W-1]) begin
            acc_next = '0;
        end else if (isum[ISUM_W-2:0] > (ISUM_W-1)'(lim_acc)) begin
            acc_next = lim_acc;
        end else begin
            acc_next = isum[ACC_W-1:0];
        end
    end

    // Drive: bounded proportional term aligned to Q.24 plus the integrator.
    always_comb begin
        if (prod_reg > PB_POS) begin
            p_cl = PB_POS;
        end else if (prod_reg < PB_NEG) begin
            p_cl = PB_NEG;
        end else begin
            p_cl = prod_reg;
        end
    end

    assign pc_x  = {{(SUM_W-PC_W){p_cl[PC_W-1]}}, p_cl[PC_W-1:0]};
    assign dsum  = (pc_x <<< SHIFT) + $signed({{(SUM_W-ACC_W){1'b0}}, acc_reg});
    assign d_int = dsum[SUM_W-2:ACC_FRAC];

    always_comb begin
        if (dsum[SUM_W-1] || set_reg == '0) begin
            drive_next = '0;
        end else if (d_int > DI_W'(cfg.output_limit)) begin
            drive_next = cfg.output_limit;
        end else begin
            drive_next = d_int[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.speed) begin
            speed_reg <= speed_next;
        end
        if (cmd.err) begin
            err_reg <= $signed(ERR_W'(set_reg) - ERR_W'(speed_reg));
        end
        if (cmd.mul) begin
            prod_reg <= prod_next;
        end
        if (cmd.drive) begin
            drive_reg <= drive_next;
        end
        if (cmd.out_load) begin
            out_drive_reg <= drive_reg;
            out_speed_reg <= MEAS_W'(speed_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (cmd.integ) begin
            acc_reg <= acc_next;
        end
    end

    assign drive_level    = out_drive_reg;
    assign measured_speed = out_speed_reg;

endmodule

// ----- hw/rtl/mspi_ctrl.sv -----
`include "motor_speed_pi_controller_top_defines.svh"

module mspi_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  div_last,
    output mspi_pkg::mspi_cmd_t   cmd
);
    import mspi_pkg::*;

    mspi_state_t state_reg;
    mspi_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_DIV;
            ST_DIV:   if (div_last) state_next = ST_SPEED;
            ST_SPEED: state_next = ST_ERR;
            ST_ERR:   state_next = ST_MUL_I;
            ST_MUL_I: state_next = ST_INTEG;
            ST_INTEG: state_next = ST_DRIVE;
            ST_DRIVE: state_next = ST_OUT;
            ST_OUT:   if (!out_valid_reg || m_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_DIV:   cmd.div_step = 1'b1;
            ST_SPEED: cmd.speed    = 1'b1;
            ST_ERR:   cmd.err      = 1'b1;
            ST_MUL_I: cmd.mul      = 1'b1;
            ST_INTEG: begin
                cmd.integ      = 1'b1;
                cmd.mul        = 1'b1;
                cmd.mul_sel_kp = 1'b1;
            end
            ST_DRIVE: cmd.drive    = 1'b1;
            ST_OUT:   cmd.out_load = !out_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

    `MSPI_ASSERT(a_no_overwrite, !cmd.out_load || !out_valid_reg || m_ready, "result overwritten")
    `MSPI_ASSERT(a_valid_drop, !$fell(out_valid_reg) || $past(m_ready), "result dropped")
    `MSPI_ASSERT_NEXT(a_accept_div, s_valid && s_ready, state_reg == ST_DIV, "no divide")
    `MSPI_ASSERT_NEXT(a_div_hold, state_reg == ST_DIV && !div_last, state_reg == ST_DIV, "short divide")

endmodule

// ----- hw/rtl/motor_speed_pi_controller_top.sv -----
// From input accept to the result register: 33 bit-serial divider steps, then
// speed, error, two multiplies on one shared multiplier, drive and output load,
// which waits until the previous result is taken. Items are handled one at a time;
// a new item is taken while the last result still waits in the output register.
// Reset (aresetn low, synchronous): configuration registers return to their
// defaults, the integrator clears to zero and no result is pending.
module motor_speed_pi_controller_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [mspi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mspi_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mspi_pkg::SET_W-1:0]        s_speed_set,
    input  logic [mspi_pkg::PERIOD_W-1:0]     s_period_ticks,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mspi_pkg::DRIVE_W-1:0]      m_drive_level,
    output logic [mspi_pkg::MEAS_W-1:0]       m_measured_speed
);
    import mspi_pkg::*;

    mspi_cfg_t cfg;
    mspi_cmd_t cmd;
    logic      div_last;

    mspi_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mspi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .div_last (div_last),
        .cmd      (cmd)
    );

    mspi_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .speed_set      (s_speed_set),
        .period_ticks   (s_period_ticks),
        .cfg            (cfg),
        .cmd            (cmd),
        .div_last       (div_last),
        .drive_level    (m_drive_level),
        .measured_speed (m_measured_speed)
    );

endmodule
